// ===== hw/rtl/adpcm_pkg.sv =====
package adpcm_pkg;

	localparam int DEFAULT_GROUP_SIZE = 8;
	localparam int FRAC_SHIFT = 11;
	localparam int COEF_W = 16;
	localparam int SAMPLE_W = 16;
	localparam int ACC_W = 32;
	localparam int NUM_COEF = 8;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;

	// register indexes on the configuration port (byte address 8*i)
	typedef enum logic [1:0] {
		REG_FIRST_LOW   = 2'd0,
		REG_FIRST_HIGH  = 2'd1,
		REG_SECOND_LOW  = 2'd2,
		REG_SECOND_HIGH = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] residual;
		logic                       start_group;
		logic signed [SAMPLE_W-1:0] history_first;
		logic signed [SAMPLE_W-1:0] history_second;
	} in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] decoded_sample;
		logic                       overrun;
	} out_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] first_low;
		logic [CFG_DATA_W-1:0] first_high;
		logic [CFG_DATA_W-1:0] second_low;
		logic [CFG_DATA_W-1:0] second_high;
	} book_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic issue;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic last;
	} stat_t;

	// pick coefficient k out of a low/high register pair
	function automatic logic signed [COEF_W-1:0] coef_sel(
		input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi,
		input logic [2:0]            k
	);
		logic [CFG_DATA_W-1:0] r;
		r = k[2] ? hi : lo;
		return r[k[1:0]*COEF_W +: COEF_W];
	endfunction

endpackage

// ===== hw/rtl/adpcm_cfg_regs.sv =====
module adpcm_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [adpcm_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [adpcm_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [adpcm_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                 pready,
	output adpcm_pkg::book_t                     books
);
	import adpcm_pkg::*;

	book_t    books_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign books  = books_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			books_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_FIRST_LOW:   books_q.first_low   <= pwdata;
				REG_FIRST_HIGH:  books_q.first_high  <= pwdata;
				REG_SECOND_LOW:  books_q.second_low  <= pwdata;
				REG_SECOND_HIGH: books_q.second_high <= pwdata;
				default:         books_q <= books_q;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_FIRST_LOW:   prdata = books_q.first_low;
			REG_FIRST_HIGH:  prdata = books_q.first_high;
			REG_SECOND_LOW:  prdata = books_q.second_low;
			REG_SECOND_HIGH: prdata = books_q.second_high;
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/adpcm_ctrl.sv =====
module adpcm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  adpcm_pkg::stat_t stat,
	output adpcm_pkg::cmd_t  cmd
);
	import adpcm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_WAIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;

	// commands decoded from state
	always_comb begin
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.issue  = (state_q == ST_RUN);
		cmd.commit = (state_q == ST_WAIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// output register: taken transaction frees it
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= stat.full ? ST_WAIT : ST_RUN;
					end
				end
				ST_RUN: begin
					if (stat.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/adpcm_datapath.sv =====
module adpcm_datapath #(
	parameter int GROUP_SIZE = adpcm_pkg::DEFAULT_GROUP_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  adpcm_pkg::in_t    in_data,
	input  adpcm_pkg::book_t  books,
	input  adpcm_pkg::cmd_t   cmd,
	output adpcm_pkg::stat_t  stat,
	output adpcm_pkg::out_t   out_data
);
	import adpcm_pkg::*;

	localparam int IDX_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
	localparam int POS_W  = $clog2(GROUP_SIZE + 1);
	localparam int STEP_W = $clog2(GROUP_SIZE + 2);
	localparam int SHR_W  = ACC_W - FRAC_SHIFT;

	logic [POS_W-1:0]           pos_q;
	logic signed [SAMPLE_W-1:0] hist_first_q;
	logic signed [SAMPLE_W-1:0] hist_second_q;
	logic signed [SAMPLE_W-1:0] store_q [GROUP_SIZE];
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       ovr_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    prod_s1;
	logic                       prod_vld_s1;
	out_t                       out_q;

	logic [STEP_W-1:0]          j;
	logic [2:0]                 pos3;
	logic [2:0]                 cidx;
	logic signed [COEF_W-1:0]   op_a;
	logic signed [SAMPLE_W-1:0] op_b;
	logic signed [SHR_W-1:0]    shr;
	logic signed [SAMPLE_W-1:0] sat;

	// status back to the controller
	assign stat.full = !in_data.start_group && (pos_q >= POS_W'(GROUP_SIZE));
	assign stat.last = (step_q == STEP_W'(pos_q) + STEP_W'(1));
	assign out_data  = out_q;

	// operand select: first history, second history, then earlier residuals
	always_comb begin
		j    = step_q - STEP_W'(2);
		pos3 = 3'(pos_q);
		cidx = pos3 - 3'd1 - 3'(j);
		if (step_q == STEP_W'(0)) begin
			op_a = coef_sel(books.first_low, books.first_high, pos3);
			op_b = hist_first_q;
		end else if (step_q == STEP_W'(1)) begin
			op_a = coef_sel(books.second_low, books.second_high, pos3);
			op_b = hist_second_q;
		end else begin
			op_a = coef_sel(books.second_low, books.second_high, cidx);
			op_b = store_q[j[IDX_W-1:0]];
		end
	end

	// scale down and clamp to 16 bits
	always_comb begin
		shr = acc_q[ACC_W-1:FRAC_SHIFT];
		if (shr > SHR_W'(32767)) begin
			sat = 16'sh7fff;
		end else if (shr < -SHR_W'(32768)) begin
			sat = -16'sh8000;
		end else begin
			sat = shr[SAMPLE_W-1:0];
		end
	end

	// group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			hist_first_q  <= '0;
			hist_second_q <= '0;
			prod_vld_s1   <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.issue;
			if (cmd.accept && in_data.start_group) begin
				pos_q         <= '0;
				hist_first_q  <= in_data.history_first;
				hist_second_q <= in_data.history_second;
			end else if (cmd.commit && !ovr_q) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// multiply-accumulate and result payload
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			prod_s1 <= op_a * op_b;
		end
		if (cmd.accept) begin
			res_q  <= in_data.residual;
			ovr_q  <= stat.full;
			step_q <= '0;
			acc_q  <= ACC_W'(in_data.residual) <<< FRAC_SHIFT;
		end else begin
			if (cmd.issue) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (prod_vld_s1) begin
				acc_q <= acc_q + prod_s1;
			end
		end
		if (cmd.commit) begin
			if (ovr_q) begin
				out_q.decoded_sample <= '0;
				out_q.overrun        <= 1'b1;
			end else begin
				out_q.decoded_sample           <= sat;
				out_q.overrun                  <= 1'b0;
				store_q[pos_q[IDX_W-1:0]]      <= res_q;
			end
		end
	end

endmodule

// ===== hw/rtl/adpcm_order2_predictor_core.sv =====
// Order-two codebook predictor for groups of up to GROUP_SIZE residuals.
// Input channel (in_valid / in_stall / in_data) carries one residual per
// transaction; start_group begins a group and latches both history samples.
// Output channel (out_valid / out_stall / out_data) returns one decoded
// sample per input transaction, or an overrun flag with sample 0 when the
// group is already full.
// One shared 16x16 multiplier runs position+2 products per item, one a
// cycle in state RUN; the last product is added to the accumulator in
// DRAIN, and the result is loaded into the output register from WAIT (an
// overrun item goes straight to WAIT). One item is in work at a time:
// in_stall is high from the accepting edge until the result is loaded, so
// the next item cannot be accepted before then.
// If the receiver stalls, the result stays in the output register; the next
// input can be accepted and computed, and waits only for that register.
// Reset clears all coefficients, the group position and the histories.
// Coefficients are written through the APB port at byte address 8*i and
// must only change between transactions.
module adpcm_order2_predictor_core #(
	parameter int GROUP_SIZE = adpcm_pkg::DEFAULT_GROUP_SIZE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  adpcm_pkg::in_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output adpcm_pkg::out_t                  out_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [adpcm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [adpcm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [adpcm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready
);
	import adpcm_pkg::*;

	book_t books;
	cmd_t  cmd;
	stat_t stat;

	adpcm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.books   (books)
	);

	adpcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	adpcm_datapath #(
		.GROUP_SIZE (GROUP_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.books    (books),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

// ===== tb/sv/adpcm_order2_checker.sv =====
module adpcm_order2_checker #(
	parameter int GROUP_SIZE = adpcm_pkg::DEFAULT_GROUP_SIZE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  adpcm_pkg::in_t                   in_data,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  adpcm_pkg::out_t                  out_data,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [adpcm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [adpcm_pkg::CFG_DATA_W-1:0] pwdata,
	output int                               failures,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import adpcm_pkg::*;

	// shadow of the codebook, unpacked into single coefficients
	logic signed [COEF_W-1:0] first_coef [NUM_COEF];
	logic signed [COEF_W-1:0] second_coef [NUM_COEF];

	// shadow of the group state
	logic signed [SAMPLE_W-1:0] group_residuals [NUM_COEF];
	int                         group_pos;
	logic signed [SAMPLE_W-1:0] hist_first;
	logic signed [SAMPLE_W-1:0] hist_second;

	out_t expected_samples [$];

	// signed 16x16 product kept as a wrapping 32-bit word
	function automatic logic signed [ACC_W-1:0] wrap_mul(
		input logic signed [COEF_W-1:0]   a,
		input logic signed [SAMPLE_W-1:0] b
	);
		logic signed [ACC_W-1:0] wa;
		logic signed [ACC_W-1:0] wb;
		wa = a;
		wb = b;
		return wa * wb;
	endfunction

	// decode one residual against the shadow state and advance it
	task automatic decode_next(input in_t item, output out_t sample);
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] scaled;
		if (item.start_group) begin
			group_pos = 0;
			hist_first = item.history_first;
			hist_second = item.history_second;
		end
		sample = '0;
		if (group_pos >= GROUP_SIZE) begin
			// group already full: flag only, state untouched
			sample.overrun = 1'b1;
		end else begin
			acc = {{(ACC_W-SAMPLE_W-FRAC_SHIFT){item.residual[SAMPLE_W-1]}},
				item.residual, {FRAC_SHIFT{1'b0}}};
			acc += wrap_mul(first_coef[group_pos], hist_first);
			acc += wrap_mul(second_coef[group_pos], hist_second);
			for (int j = 0; j < group_pos; j++)
				acc += wrap_mul(second_coef[group_pos-1-j], group_residuals[j]);
			scaled = acc >>> FRAC_SHIFT;
			if (scaled > 32767)
				sample.decoded_sample = 16'sh7FFF;
			else if (scaled < -32768)
				sample.decoded_sample = 16'sh8000;
			else
				sample.decoded_sample = scaled[SAMPLE_W-1:0];
			group_residuals[group_pos] = item.residual;
			group_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		out_t want;
		out_t got;
		reg_idx_t ridx;
		if (!arst_n) begin
			for (int k = 0; k < NUM_COEF; k++) begin
				first_coef[k] = '0;
				second_coef[k] = '0;
				group_residuals[k] = '0;
			end
			group_pos = 0;
			hist_first = '0;
			hist_second = '0;
			expected_samples.delete();
			failures = 0;
			pending = 0;
		end else begin
			// output side first: a result never belongs to an item taken this edge
			if (out_valid && !out_stall) begin
				got = out_data;
				if (expected_samples.size() == 0) begin
					$error("result with nothing expected: decoded_sample %0d overrun %0b",
						got.decoded_sample, got.overrun);
					failures++;
				end else begin
					want = expected_samples.pop_front();
					if (got.decoded_sample !== want.decoded_sample) begin
						$error("decoded_sample: expected %0d, got %0d",
							want.decoded_sample, got.decoded_sample);
						failures++;
					end
					if (got.overrun !== want.overrun) begin
						$error("overrun: expected %0b, got %0b", want.overrun, got.overrun);
						failures++;
					end
				end
			end
			// input transaction
			if (in_valid && !in_stall) begin
				decode_next(in_data, want);
				expected_samples.push_back(want);
			end
			// codebook writes
			if (psel && penable && pwrite && pready) begin
				ridx = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
				for (int k = 0; k < 4; k++) begin
					case (ridx)
						REG_FIRST_LOW: begin
							first_coef[k] = pwdata[16*k +: 16];
						end
						REG_FIRST_HIGH: begin
							first_coef[k+4] = pwdata[16*k +: 16];
						end
						REG_SECOND_LOW: begin
							second_coef[k] = pwdata[16*k +: 16];
						end
						REG_SECOND_HIGH: begin
							second_coef[k+4] = pwdata[16*k +: 16];
						end
						default: begin
						end
					endcase
				end
			end
			pending = expected_samples.size();
		end
	end

endmodule

// ===== tb/sv/tb_adpcm_order2_predictor_core.sv =====
module tb_adpcm_order2_predictor_core;
	timeunit 1ns;
	timeprecision 1ps;

	import adpcm_pkg::*;

	typedef enum int {
		BOOK_RANDOM,
		BOOK_SMALL,
		BOOK_MAX,
		BOOK_MIN,
		BOOK_ZERO
	} book_kind_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_t                  out_data;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int failures;
	int pending;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_cycles = 0;
	int sent_items = 0;

	adpcm_order2_predictor_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	adpcm_order2_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.failures (failures),
		.pending  (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off when requested
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall = 1'b1;
				hold_cycles--;
			end else begin
				out_stall = ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	// one input transaction, entered and left at a falling edge
	task automatic send_item(
		input logic signed [SAMPLE_W-1:0] residual,
		input logic                       start,
		input logic signed [SAMPLE_W-1:0] h_first,
		input logic signed [SAMPLE_W-1:0] h_second
	);
		logic [63:0] noise;
		in_valid = 1'b0;
		while ($urandom_range(0, 99) < send_idle) begin
			noise = {$urandom, $urandom};
			in_data = noise[$bits(in_t)-1:0];
			@(negedge clk);
		end
		in_data.residual = residual;
		in_data.start_group = start;
		in_data.history_first = h_first;
		in_data.history_second = h_second;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
		sent_items++;
	endtask

	task automatic cfg_write(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// block drained; allow for the longest item in flight
	task automatic wait_drained();
		while (pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] book_word(input book_kind_t kind);
		logic [CFG_DATA_W-1:0] w;
		case (kind)
			BOOK_RANDOM: w = {$urandom, $urandom};
			BOOK_SMALL: begin
				for (int k = 0; k < 4; k++)
					w[16*k +: 16] = 16'($urandom_range(0, 8191) - 4096);
			end
			BOOK_MAX: w = {4{16'h7FFF}};
			BOOK_MIN: w = {4{16'h8000}};
			default: w = '0;
		endcase
		return w;
	endfunction

	// rewrite all four codebook registers; mixed picks a kind per register
	task automatic program_books(input book_kind_t kind, input bit mixed);
		book_kind_t k;
		wait_drained();
		for (int r = 0; r < 4; r++) begin
			k = mixed ? book_kind_t'($urandom_range(0, 4)) : kind;
			if (mixed && $urandom_range(0, 1))
				k = BOOK_SMALL;
			cfg_write(reg_idx_t'(r), book_word(k));
		end
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($urandom_range(0, 4095) - 2048);
		endcase
	endfunction

	// mostly whole groups, some overrun tails and some without a start
	task automatic send_group();
		int len;
		bit opens;
		logic signed [SAMPLE_W-1:0] h_first;
		logic signed [SAMPLE_W-1:0] h_second;
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
		opens = ($urandom_range(0, 15) != 0);
		h_first = pick_sample();
		h_second = pick_sample();
		if ($urandom_range(0, 11) == 0)
			while (pending != 0) @(negedge clk);
		for (int i = 0; i < len; i++) begin
			if (i == 0)
				send_item(pick_sample(), opens, h_first, h_second);
			else
				send_item(pick_sample(), 1'b0, 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int phase_start;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// no start after reset: zero books, zero histories
		send_item(16'sh8000, 1'b0, 16'sh7FFF, 16'sh8000);
		send_item(16'sh7FFF, 1'b0, 16'sh8000, 16'sh7FFF);
		send_item(16'sh0001, 1'b0, 16'sh0000, 16'sh0000);

		// largest coefficients: saturation high, accumulator wrap, overrun
		program_books(BOOK_MAX, 1'b0);
		send_item(16'sh7FFF, 1'b1, 16'sh7FFF, 16'sh7FFF);
		for (int i = 1; i < 8; i++)
			send_item(16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000);
		send_item(16'sh1234, 1'b0, 16'sh7FFF, 16'sh7FFF);
		send_item(16'sh8000, 1'b0, 16'sh8000, 16'sh8000);

		// most negative coefficients, then a restart in the middle of a group
		program_books(BOOK_MIN, 1'b0);
		send_item(16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000);
		send_item(16'sh8000, 1'b0, 16'sh0000, 16'sh0000);
		send_item(16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000);
		send_item(16'sh0000, 1'b1, 16'sh8000, 16'sh8000);
		send_item(16'sh8000, 1'b0, 16'sh0000, 16'sh0000);

		// random part: three idling modes, three codebook settings each
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_idle = 22; recv_idle = 62; end
				1: begin send_idle = 62; recv_idle = 22; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			for (int ph = 0; ph < 3; ph++) begin
				if (ph == 2 && mode == 2)
					program_books(BOOK_ZERO, 1'b0);
				else
					program_books(BOOK_RANDOM, 1'b1);
				if (mode == 0 && ph == 0) begin
					// long receiver hold-off while items keep coming
					@(posedge clk);
					hold_cycles = 250;
					@(negedge clk);
				end
				phase_start = sent_items;
				while (sent_items - phase_start < 110)
					send_group();
			end
		end

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (failures == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
